>>> design/fdv_pkg.sv
// Shared types and constants of the finite-difference velocity block.
// Used by the interfaces, the controller, the datapath and the divider.
package fdv_pkg;

	localparam int JOINTS  = 6;
	localparam int LANE_W  = 3;
	localparam int TIME_W  = 48;
	localparam int POS_W   = 32;
	localparam int DIFF_W  = POS_W + 1;
	localparam int NS_W    = 30;
	localparam int PROD_W  = DIFF_W + NS_W;
	localparam int NUM_W   = PROD_W + 1;
	localparam int DEN_W   = TIME_W + 1;
	localparam int QUO_W   = 33;
	localparam int CNT_W   = 6;

	localparam logic [NS_W-1:0] NS_PER_S = NS_W'(1000000000);

	// Job codes double as the difference_kind output code.
	typedef logic [1:0] job_t;
	localparam job_t JOB_FWD    = 2'd0;
	localparam job_t JOB_CEN    = 2'd1;
	localparam job_t JOB_BWD    = 2'd2;
	localparam job_t JOB_SINGLE = 2'd3;

	typedef struct packed {
		logic              load;
		logic              push;
		logic              setup;
		job_t              job;
		logic              diff;
		logic              mul;
		logic              div_start;
		logic              store_zero;
		logic              store_q;
		logic [LANE_W-1:0] lane;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic cur_last;
		logic lane_live;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

>>> design/fdv_if.sv
// Valid/ready channel interfaces for trajectory points and velocity results.
// Depends on fdv_pkg for field widths.
interface fdv_in_if;
	logic                             valid;
	logic                             ready;
	logic [fdv_pkg::TIME_W-1:0]       time_ns;
	logic signed [fdv_pkg::POS_W-1:0] position_0;
	logic signed [fdv_pkg::POS_W-1:0] position_1;
	logic signed [fdv_pkg::POS_W-1:0] position_2;
	logic signed [fdv_pkg::POS_W-1:0] position_3;
	logic signed [fdv_pkg::POS_W-1:0] position_4;
	logic signed [fdv_pkg::POS_W-1:0] position_5;
	logic                             last_point;

	modport source (output valid, time_ns, position_0, position_1, position_2, position_3,
		position_4, position_5, last_point, input ready);
	modport sink (input valid, time_ns, position_0, position_1, position_2, position_3,
		position_4, position_5, last_point, output ready);
endinterface

interface fdv_out_if;
	logic                             valid;
	logic                             ready;
	logic [fdv_pkg::TIME_W-1:0]       point_time_ns;
	logic signed [fdv_pkg::POS_W-1:0] velocity_0;
	logic signed [fdv_pkg::POS_W-1:0] velocity_1;
	logic signed [fdv_pkg::POS_W-1:0] velocity_2;
	logic signed [fdv_pkg::POS_W-1:0] velocity_3;
	logic signed [fdv_pkg::POS_W-1:0] velocity_4;
	logic signed [fdv_pkg::POS_W-1:0] velocity_5;
	logic [1:0]                       difference_kind;
	logic                             bad_interval;
	logic                             last_result;

	modport source (output valid, point_time_ns, velocity_0, velocity_1, velocity_2,
		velocity_3, velocity_4, velocity_5, difference_kind, bad_interval, last_result,
		input ready);
	modport sink (input valid, point_time_ns, velocity_0, velocity_1, velocity_2,
		velocity_3, velocity_4, velocity_5, difference_kind, bad_interval, last_result,
		output ready);
endinterface

>>> design/finite_difference_velocity.sv
// Top level of the finite-difference joint velocity estimator.
// Depends on fdv_pkg, fdv_if, fdv_ctrl and fdv_dp.
//
// Usage: trajectory points enter on the samples channel (valid/ready), each word
// a time stamp and six Q16.16 joint positions plus a final-point mark. Velocity
// words leave on the velocities channel one point late: the first point gets a
// forward difference, inner points a central one, and a point marked final
// releases two words, the pending point and then a backward difference for it.
// A lone final point yields one word of kind "single point" with zero velocities.
// cfg_write/cfg_data set the number of joints in use (default six); write it only
// while the block is idle.
// Timing: one point is worked at a time. Each active joint is dominated by the
// restoring divider that develops one quotient bit per cycle, and is cut short
// when the quotient is seen to saturate at the start; an unused joint or a bad
// interval skips the divider. samples.ready stays low until the point's words
// are all loaded into the result register.
// Reset clears the trajectory position, so the next point is a first point, and
// sets the joint count to six. When the receiver stalls, a finished word waits in
// the result register and the block holds before overwriting it.
module finite_difference_velocity (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [fdv_pkg::LANE_W-1:0]  cfg_data,
	fdv_in_if.sink                      samples,
	fdv_out_if.source                   velocities
);

	fdv_pkg::cmd_t cmd;
	fdv_pkg::sts_t sts;
	logic          sample_ready;

	assign samples.ready = sample_ready;

	fdv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (samples.valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	fdv_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.samples    (samples),
		.velocities (velocities),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> design/fdv_div.sv
// Restoring divider, one quotient bit per cycle, with early overflow detection.
// Depends on fdv_pkg for operand widths.
module fdv_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fdv_pkg::NUM_W-1:0]   num,
	input  logic [fdv_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic                        ovf,
	output logic [fdv_pkg::QUO_W-1:0]   quo
);

	localparam int HI_W = fdv_pkg::NUM_W - fdv_pkg::QUO_W;

	logic [fdv_pkg::DEN_W-1:0] rem_q;
	logic [fdv_pkg::DEN_W-1:0] den_q;
	logic [fdv_pkg::QUO_W-1:0] nq_q;
	logic [fdv_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ovf_q;

	logic [fdv_pkg::DEN_W:0]   rem2;
	logic                      ge;
	logic                      start_ovf;

	// A quotient of 2^33 or more saturates anyway, so only 33 bits are developed.
	assign start_ovf = fdv_pkg::DEN_W'(num[fdv_pkg::NUM_W-1 -: HI_W]) >= den;
	assign rem2      = {rem_q, nq_q[fdv_pkg::QUO_W-1]};
	assign ge        = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			ovf_q  <= start_ovf;
			done_q <= start_ovf;
			busy_q <= !start_ovf;
			cnt_q  <= fdv_pkg::CNT_W'(fdv_pkg::QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == fdv_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= fdv_pkg::DEN_W'(num[fdv_pkg::NUM_W-1 -: HI_W]);
			nq_q  <= num[fdv_pkg::QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? fdv_pkg::DEN_W'(rem2 - {1'b0, den_q}) : rem2[fdv_pkg::DEN_W-1:0];
			nq_q  <= {nq_q[fdv_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = nq_q;

endmodule

>>> design/fdv_dp.sv
// Datapath: point history, interval, per-joint scaling and the result register.
// Depends on fdv_pkg, fdv_if and fdv_div.
module fdv_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [fdv_pkg::LANE_W-1:0]  cfg_data,
	fdv_in_if.sink                      samples,
	fdv_out_if.source                   velocities,
	input  fdv_pkg::cmd_t               cmd,
	output fdv_pkg::sts_t               sts
);

	localparam logic [fdv_pkg::PROD_W-1:0] NS_PER_S_EXT = fdv_pkg::PROD_W'(fdv_pkg::NS_PER_S);

	logic [fdv_pkg::POS_W-1:0]  cur_in [fdv_pkg::JOINTS];
	logic [fdv_pkg::POS_W-1:0]  cur_pos_q [fdv_pkg::JOINTS];
	logic [fdv_pkg::POS_W-1:0]  new_pos_q [fdv_pkg::JOINTS];
	logic [fdv_pkg::POS_W-1:0]  old_pos_q [fdv_pkg::JOINTS];
	logic [fdv_pkg::POS_W-1:0]  vel_q [fdv_pkg::JOINTS];
	logic [fdv_pkg::TIME_W-1:0] cur_time_q, new_time_q, old_time_q;
	logic                       cur_last_q;
	logic [fdv_pkg::LANE_W-1:0] active_q;

	fdv_pkg::job_t              job_q;
	logic [fdv_pkg::TIME_W-1:0] dt_q;
	logic [fdv_pkg::TIME_W-1:0] ptime_q;
	logic                       bad_q;
	logic                       zero_q;
	logic                       neg_q;
	logic [fdv_pkg::DIFF_W-1:0] mag_q;
	logic [fdv_pkg::PROD_W-1:0] prod_q;

	logic                       out_valid_q;
	logic [fdv_pkg::TIME_W-1:0] out_time_q;
	logic [fdv_pkg::POS_W-1:0]  out_vel_q [fdv_pkg::JOINTS];
	fdv_pkg::job_t              out_kind_q;
	logic                       out_bad_q;
	logic                       out_last_q;

	logic [fdv_pkg::TIME_W-1:0] t_early;
	logic [fdv_pkg::LANE_W-1:0] used;
	logic [fdv_pkg::POS_W-1:0]  later, earlier;
	logic [fdv_pkg::DIFF_W-1:0] diff;
	logic                       div_done, div_ovf;
	logic [fdv_pkg::QUO_W-1:0]  quo;
	logic [fdv_pkg::POS_W-1:0]  sat_val;
	logic                       out_free;

	assign cur_in[0] = samples.position_0;
	assign cur_in[1] = samples.position_1;
	assign cur_in[2] = samples.position_2;
	assign cur_in[3] = samples.position_3;
	assign cur_in[4] = samples.position_4;
	assign cur_in[5] = samples.position_5;

	// Register for active joints: zero counts as one, anything above the lane count clamps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= fdv_pkg::LANE_W'(fdv_pkg::JOINTS);
		end else if (cfg_write) begin
			active_q <= cfg_data;
		end
	end

	always_comb begin
		if (active_q == '0) begin
			used = fdv_pkg::LANE_W'(1);
		end else if (active_q > fdv_pkg::LANE_W'(fdv_pkg::JOINTS)) begin
			used = fdv_pkg::LANE_W'(fdv_pkg::JOINTS);
		end else begin
			used = active_q;
		end
	end

	// Point history.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_pos_q  <= cur_in;
			cur_time_q <= samples.time_ns;
			cur_last_q <= samples.last_point;
		end
		if (cmd.push) begin
			old_pos_q  <= new_pos_q;
			new_pos_q  <= cur_pos_q;
			old_time_q <= new_time_q;
			new_time_q <= cur_time_q;
		end
	end

	// Per-result setup: the earlier point is the older one only for a central difference.
	assign t_early = (cmd.job == fdv_pkg::JOB_CEN) ? old_time_q : new_time_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			job_q   <= cmd.job;
			zero_q  <= cmd.job == fdv_pkg::JOB_SINGLE;
			bad_q   <= (cmd.job != fdv_pkg::JOB_SINGLE) && (cur_time_q <= t_early);
			dt_q    <= cur_time_q - t_early;
			ptime_q <= (cmd.job == fdv_pkg::JOB_FWD || cmd.job == fdv_pkg::JOB_CEN) ?
				new_time_q : cur_time_q;
		end
	end

	// Scaling of one joint: difference, magnitude times 1e9, then the divider.
	assign later   = cur_pos_q[cmd.lane];
	assign earlier = (job_q == fdv_pkg::JOB_CEN) ? old_pos_q[cmd.lane] : new_pos_q[cmd.lane];
	assign diff    = {later[fdv_pkg::POS_W-1], later} - {earlier[fdv_pkg::POS_W-1], earlier};

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			neg_q <= diff[fdv_pkg::DIFF_W-1];
			mag_q <= diff[fdv_pkg::DIFF_W-1] ? fdv_pkg::DIFF_W'(0) - diff : diff;
		end
		if (cmd.mul) begin
			prod_q <= fdv_pkg::PROD_W'(mag_q) * fdv_pkg::PROD_W'(NS_PER_S_EXT);
		end
	end

	// Rounded quotient: (2*m + dt) / (2*dt).
	fdv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({prod_q, 1'b0} + fdv_pkg::NUM_W'(dt_q)),
		.den    ({dt_q, 1'b0}),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (quo)
	);

	always_comb begin
		if (neg_q) begin
			if (div_ovf || quo > fdv_pkg::QUO_W'(33'h0_8000_0000)) begin
				sat_val = 32'h8000_0000;
			end else begin
				sat_val = fdv_pkg::POS_W'(fdv_pkg::QUO_W'(0) - quo);
			end
		end else begin
			if (div_ovf || quo[fdv_pkg::QUO_W-1 -: 2] != 2'b00) begin
				sat_val = 32'h7FFF_FFFF;
			end else begin
				sat_val = quo[fdv_pkg::POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_zero) begin
			vel_q[cmd.lane] <= '0;
		end else if (cmd.store_q) begin
			vel_q[cmd.lane] <= sat_val;
		end
	end

	// Result register.
	assign out_free = !out_valid_q || velocities.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (velocities.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_time_q <= ptime_q;
			out_vel_q  <= vel_q;
			out_kind_q <= job_q;
			out_bad_q  <= bad_q;
			out_last_q <= job_q == fdv_pkg::JOB_BWD || job_q == fdv_pkg::JOB_SINGLE;
		end
	end

	assign velocities.valid           = out_valid_q;
	assign velocities.point_time_ns   = out_time_q;
	assign velocities.velocity_0      = out_vel_q[0];
	assign velocities.velocity_1      = out_vel_q[1];
	assign velocities.velocity_2      = out_vel_q[2];
	assign velocities.velocity_3      = out_vel_q[3];
	assign velocities.velocity_4      = out_vel_q[4];
	assign velocities.velocity_5      = out_vel_q[5];
	assign velocities.difference_kind = out_kind_q;
	assign velocities.bad_interval    = out_bad_q;
	assign velocities.last_result     = out_last_q;

	assign sts.cur_last  = cur_last_q;
	assign sts.lane_live = (cmd.lane < used) && !bad_q && !zero_q;
	assign sts.div_done  = div_done;
	assign sts.out_free  = out_free;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten before the word was taken");

	a_store_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_q |-> div_done)
		else $error("quotient stored before the divider finished");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(velocities.valid && velocities.bad_interval) |->
		(velocities.velocity_0 == '0 && velocities.velocity_1 == '0 &&
		velocities.velocity_2 == '0 && velocities.velocity_3 == '0 &&
		velocities.velocity_4 == '0 && velocities.velocity_5 == '0))
		else $error("nonzero velocity on a bad interval");

	a_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(velocities.valid && velocities.difference_kind == fdv_pkg::JOB_SINGLE) |->
		(velocities.last_result && !velocities.bad_interval &&
		velocities.velocity_0 == '0 && velocities.velocity_5 == '0))
		else $error("single point result malformed");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(velocities.valid && velocities.last_result) |->
		(velocities.difference_kind == fdv_pkg::JOB_BWD ||
		velocities.difference_kind == fdv_pkg::JOB_SINGLE))
		else $error("final result carries a wrong difference kind");

endmodule

>>> design/fdv_ctrl.sv
// Controller: trajectory position, result sequencing and the per-joint loop.
// Depends on fdv_pkg for the command and status structs.
module fdv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_ready,
	input  fdv_pkg::sts_t sts,
	output fdv_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SETUP  = 3'd2;
	localparam logic [2:0] S_LANE   = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_DSTART = 3'd5;
	localparam logic [2:0] S_DIV    = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0]                 state_q, state_n;
	logic [1:0]                 seen_q, seen_n;
	logic [fdv_pkg::LANE_W-1:0] lane_q, lane_n;
	fdv_pkg::job_t              job_q, job_n;
	logic                       lane_end;

	assign lane_end = lane_q == fdv_pkg::LANE_W'(fdv_pkg::JOINTS - 1);

	always_comb begin
		state_n      = state_q;
		seen_n       = seen_q;
		lane_n       = lane_q;
		job_n        = job_q;
		cmd          = '0;
		cmd.job      = job_q;
		cmd.lane     = lane_q;
		sample_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_n  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (seen_q == 2'd0) begin
					if (sts.cur_last) begin
						job_n   = fdv_pkg::JOB_SINGLE;
						state_n = S_SETUP;
					end else begin
						cmd.push = 1'b1;
						seen_n   = 2'd1;
						state_n  = S_IDLE;
					end
				end else begin
					// A count of three cannot occur and behaves as two.
					job_n   = (seen_q == 2'd1) ? fdv_pkg::JOB_FWD : fdv_pkg::JOB_CEN;
					state_n = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				lane_n    = '0;
				state_n   = S_LANE;
			end
			S_LANE: begin
				if (sts.lane_live) begin
					cmd.diff = 1'b1;
					state_n  = S_MUL;
				end else begin
					cmd.store_zero = 1'b1;
					lane_n         = lane_q + 1'b1;
					state_n        = lane_end ? S_EMIT : S_LANE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_n = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_n       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.store_q = 1'b1;
					lane_n      = lane_q + 1'b1;
					state_n     = lane_end ? S_EMIT : S_LANE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (job_q == fdv_pkg::JOB_SINGLE || job_q == fdv_pkg::JOB_BWD) begin
						seen_n  = 2'd0;
						state_n = S_IDLE;
					end else if (sts.cur_last) begin
						job_n   = fdv_pkg::JOB_BWD;
						state_n = S_SETUP;
					end else begin
						cmd.push = 1'b1;
						seen_n   = 2'd2;
						state_n  = S_IDLE;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q  <= 2'd0;
			lane_q  <= '0;
			job_q   <= fdv_pkg::JOB_FWD;
		end else begin
			state_q <= state_n;
			seen_q  <= seen_n;
			lane_q  <= lane_n;
			job_q   <= job_n;
		end
	end

endmodule

>>> dv/tb.sv
// Self-checking testbench of finite_difference_velocity: random and directed trajectories.
// Uses fdv_pkg and the fdv_in_if/fdv_out_if interfaces from the design folder.
// A predictor of the block's own builds the expected velocity words, and a monitor checks them.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fdv_pkg::*;

	localparam int CYCLE_LIMIT   = 3000000;
	localparam int SETTLE_CYCLES = 600;
	localparam int RANDOM_POINTS = 880;
	localparam int HOLD_CYCLES   = 3000;

	typedef logic [JOINTS-1:0][POS_W-1:0] joint_vec_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		joint_vec_t        pos;
		logic              last;
	} point_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		joint_vec_t        vel;
		job_t              kind;
		logic              bad;
		logic              last;
	} vel_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic [LANE_W-1:0] cfg_data;

	fdv_in_if  samples_if ();
	fdv_out_if vel_if ();

	finite_difference_velocity u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.samples    (samples_if),
		.velocities (vel_if)
	);

	// Predictor state: the two points kept by the block and the joint count.
	joint_vec_t        older_pos;
	joint_vec_t        newer_pos;
	logic [TIME_W-1:0] older_stamp;
	logic [TIME_W-1:0] newer_stamp;
	int                points_held;
	logic [LANE_W-1:0] joint_count;

	vel_word_t         velocity_words_due[$];

	// Trajectory generator state.
	logic [TIME_W-1:0] traj_stamp;
	joint_vec_t        traj_pos;

	int  cycle_count;
	int  error_count;
	int  points_sent;
	int  words_checked;
	int  bad_words;
	int  config_writes;
	int  hold_left;
	int  sink_stall;
	bit  steady_source;
	bit  steady_sink;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words still due", cycle_count,
			velocity_words_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Rounded, saturated (diff * 1e9) / dt as a 32-bit pattern.
	function automatic logic [POS_W-1:0] scaled_rate(longint diff, logic [TIME_W-1:0] dt);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (diff < 0) ? 128'(-diff) : 128'(diff);
		q = (mag * 128'(NS_PER_S) * 2 + 128'(dt)) / (128'(dt) * 2);
		if (diff < 0) begin
			if (q > 128'h8000_0000)
				q = 128'h8000_0000;
			return POS_W'(~q + 128'd1);
		end
		if (q > 128'h7FFF_FFFF)
			q = 128'h7FFF_FFFF;
		return POS_W'(q);
	endfunction

	function automatic vel_word_t difference_word(logic [TIME_W-1:0] stamp, joint_vec_t earlier,
			joint_vec_t later, logic [TIME_W-1:0] t_early, logic [TIME_W-1:0] t_late,
			job_t kind, logic last);
		vel_word_t w;
		int        n;
		int        j;
		longint    diff;
		n = int'(joint_count);
		if (n < 1)
			n = 1;
		if (n > JOINTS)
			n = JOINTS;
		w.stamp = stamp;
		w.kind  = kind;
		w.bad   = (t_late <= t_early);
		w.last  = last;
		for (j = 0; j < JOINTS; j++) begin
			diff = longint'($signed(later[j])) - longint'($signed(earlier[j]));
			w.vel[j] = (!w.bad && j < n) ? scaled_rate(diff, t_late - t_early) : '0;
		end
		return w;
	endfunction

	function automatic void push_word(vel_word_t w);
		velocity_words_due.insert(velocity_words_due.size(), w);
		if (w.bad)
			bad_words++;
	endfunction

	// Advances the predictor by one accepted point.
	function automatic void track_point(point_t p);
		vel_word_t w;
		if (points_held == 0) begin
			if (p.last) begin
				w.stamp = p.stamp;
				w.vel   = '0;
				w.kind  = JOB_SINGLE;
				w.bad   = 1'b0;
				w.last  = 1'b1;
				push_word(w);
			end else begin
				newer_pos   = p.pos;
				newer_stamp = p.stamp;
				points_held = 1;
			end
			return;
		end
		if (points_held == 1)
			push_word(difference_word(newer_stamp, newer_pos, p.pos, newer_stamp, p.stamp,
				JOB_FWD, 1'b0));
		else
			push_word(difference_word(newer_stamp, older_pos, p.pos, older_stamp, p.stamp,
				JOB_CEN, 1'b0));
		if (p.last) begin
			push_word(difference_word(p.stamp, newer_pos, p.pos, newer_stamp, p.stamp,
				JOB_BWD, 1'b1));
			points_held = 0;
		end else begin
			older_pos   = newer_pos;
			older_stamp = newer_stamp;
			newer_pos   = p.pos;
			newer_stamp = p.stamp;
			points_held = 2;
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 4);
	endfunction

	task automatic send_point(point_t p);
		int gap;
		samples_if.time_ns    <= p.stamp;
		samples_if.position_0 <= p.pos[0];
		samples_if.position_1 <= p.pos[1];
		samples_if.position_2 <= p.pos[2];
		samples_if.position_3 <= p.pos[3];
		samples_if.position_4 <= p.pos[4];
		samples_if.position_5 <= p.pos[5];
		samples_if.last_point <= p.last;
		samples_if.valid      <= 1'b1;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		track_point(p);
		points_sent++;
		gap = (steady_source || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (velocity_words_due.size() != 0)
			@(posedge clk);
	endtask

	// A first point gives no word, so the block may still be busy once the queue
	// is empty; let it settle before touching the register.
	task automatic write_joint_count(logic [LANE_W-1:0] count);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data  <= count;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write   <= 1'b0;
		joint_count = count;
		config_writes++;
	endtask

	// Ready side of the velocity channel, with the long hold-off counted here.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				vel_if.ready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				vel_if.ready <= 1'b0;
			end else if (!steady_sink && $urandom_range(0, 99) < 30) begin
				sink_stall = pick_gap() - 1;
				vel_if.ready <= 1'b0;
			end else begin
				vel_if.ready <= 1'b1;
			end
		end
	end

	// Checks every accepted velocity word against the oldest expected one.
	initial begin
		vel_word_t got;
		vel_word_t want;
		bit        differs;
		int        j;
		forever begin
			@(posedge clk);
			if (arst_n && vel_if.valid && vel_if.ready) begin
				got.stamp  = vel_if.point_time_ns;
				got.vel[0] = vel_if.velocity_0;
				got.vel[1] = vel_if.velocity_1;
				got.vel[2] = vel_if.velocity_2;
				got.vel[3] = vel_if.velocity_3;
				got.vel[4] = vel_if.velocity_4;
				got.vel[5] = vel_if.velocity_5;
				got.kind   = vel_if.difference_kind;
				got.bad    = vel_if.bad_interval;
				got.last   = vel_if.last_result;
				if (velocity_words_due.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected word at cycle %0d: time %h kind %0d",
							cycle_count, got.stamp, got.kind);
				end else begin
					want = velocity_words_due.pop_front();
					words_checked++;
					differs = (got.stamp !== want.stamp) || (got.kind !== want.kind) ||
						(got.bad !== want.bad) || (got.last !== want.last);
					for (j = 0; j < JOINTS; j++)
						if (got.vel[j] !== want.vel[j])
							differs = 1'b1;
					if (differs) begin
						error_count++;
						if (error_count <= 10) begin
							$display("mismatch at cycle %0d, word %0d", cycle_count,
								words_checked);
							$display("  expected time %h vel %h %h %h %h %h %h kind %0d bad %0d last %0d",
								want.stamp, want.vel[0], want.vel[1], want.vel[2],
								want.vel[3], want.vel[4], want.vel[5], want.kind,
								want.bad, want.last);
							$display("  actual   time %h vel %h %h %h %h %h %h kind %0d bad %0d last %0d",
								got.stamp, got.vel[0], got.vel[1], got.vel[2],
								got.vel[3], got.vel[4], got.vel[5], got.kind,
								got.bad, got.last);
						end
					end
				end
			end
		end
	end

	function automatic logic [TIME_W-1:0] next_stamp(logic [TIME_W-1:0] t);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return t + TIME_W'($urandom_range(1, 100000));
		if (r < 80)
			return t + TIME_W'($urandom_range(1, 2000000000));
		if (r < 88)
			return t + TIME_W'($urandom);
		if (r < 94)
			return t;
		return t - TIME_W'($urandom_range(1, 1000));
	endfunction

	function automatic logic [POS_W-1:0] next_position(logic [POS_W-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return prev + POS_W'($urandom_range(0, 2000)) - POS_W'(1000);
		if (r < 85)
			return prev + POS_W'($signed($urandom) >>> 8);
		if (r < 90)
			return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return $urandom;
	endfunction

	// Sends one trajectory of random content; pause_at names the point after
	// which the sender waits for every due word, or is negative for none.
	task automatic run_trajectory(int length, int pause_at);
		point_t p;
		int     k;
		int     j;
		traj_stamp = $urandom_range(0, 1) ? TIME_W'($urandom_range(0, 1000000))
			: TIME_W'({$urandom, $urandom});
		for (j = 0; j < JOINTS; j++)
			traj_pos[j] = $urandom_range(0, 1) ? POS_W'($signed($urandom) >>> 12) : $urandom;
		for (k = 0; k < length; k++) begin
			if (k > 0) begin
				traj_stamp = next_stamp(traj_stamp);
				for (j = 0; j < JOINTS; j++)
					traj_pos[j] = next_position(traj_pos[j]);
			end
			p.stamp = traj_stamp;
			p.pos   = traj_pos;
			p.last  = (k == length - 1);
			send_point(p);
			if (k == pause_at)
				wait_drained();
		end
	endtask

	task automatic test_directed();
		point_t p;
		int     j;
		// A lone final point.
		p.stamp = TIME_W'(100);
		p.pos   = {JOINTS{32'h1234_5678}};
		p.last  = 1'b1;
		send_point(p);
		// Full-range rise over 1 ns saturates high.
		p.stamp = TIME_W'(0);
		p.pos   = {JOINTS{32'h8000_0000}};
		p.last  = 1'b0;
		send_point(p);
		p.stamp = TIME_W'(1);
		p.pos   = {JOINTS{32'h7FFF_FFFF}};
		p.last  = 1'b1;
		send_point(p);
		// Full-range fall at the top of the time range saturates low.
		p.stamp = 48'hFFFF_FFFF_FFFE;
		p.pos   = {JOINTS{32'h7FFF_FFFF}};
		p.last  = 1'b0;
		send_point(p);
		p.stamp = 48'hFFFF_FFFF_FFFF;
		p.pos   = {JOINTS{32'h8000_0000}};
		p.last  = 1'b1;
		send_point(p);
		// Half steps round away from zero on both signs.
		p.stamp = TIME_W'(0);
		p.pos   = '0;
		p.last  = 1'b0;
		send_point(p);
		p.stamp = 48'd2000000000;
		for (j = 0; j < JOINTS; j++)
			p.pos[j] = (j % 2) ? {POS_W{1'b1}} : POS_W'(1);
		send_point(p);
		p.stamp = 48'd4000000000;
		for (j = 0; j < JOINTS; j++)
			p.pos[j] = (j % 2) ? -POS_W'(3) : POS_W'(3);
		p.last  = 1'b1;
		send_point(p);
		// Equal times on a two-point trajectory.
		p.stamp = TIME_W'(500);
		p.pos   = {JOINTS{32'h0001_0000}};
		p.last  = 1'b0;
		send_point(p);
		p.pos   = {JOINTS{32'h0003_0000}};
		p.last  = 1'b1;
		send_point(p);
		// Falling times: every difference has a bad interval.
		for (j = 0; j < 3; j++) begin
			p.stamp = TIME_W'(900 - 100 * j);
			p.pos   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			p.last  = (j == 2);
			send_point(p);
		end
		// Bad first interval, but the central and backward ones are good.
		for (j = 0; j < 3; j++) begin
			p.stamp = (j == 2) ? TIME_W'(20) : TIME_W'(10);
			p.pos   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			p.last  = (j == 2);
			send_point(p);
		end
		// Widest interval with a small change.
		p.stamp = TIME_W'(0);
		p.pos   = {JOINTS{32'h0000_0100}};
		p.last  = 1'b0;
		send_point(p);
		p.stamp = 48'hFFFF_FFFF_FFFF;
		p.pos   = {JOINTS{32'hFFFF_FF00}};
		p.last  = 1'b1;
		send_point(p);
		// Mixed values on a three-point trajectory.
		for (j = 0; j < 3; j++) begin
			p.stamp = TIME_W'(1000 + 1250 * j);
			p.pos   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			p.last  = (j == 2);
			send_point(p);
		end
	endtask

	task automatic test_joint_counts();
		int c;
		for (c = 0; c < 8; c++) begin
			write_joint_count(LANE_W'(c));
			run_trajectory($urandom_range(1, 4), -1);
		end
	endtask

	// The receiver holds off while the sender keeps offering points, so the
	// block fills up and stalls its input.
	task automatic test_backpressure();
		wait_drained();
		steady_source = 1'b1;
		hold_left     = HOLD_CYCLES;
		run_trajectory(10, -1);
		steady_source = 1'b0;
		wait_drained();
	endtask

	task automatic test_drain_pause();
		run_trajectory(7, 2);
		run_trajectory(3, 0);
		wait_drained();
	endtask

	task automatic test_random();
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < RANDOM_POINTS) begin
			if ($urandom_range(0, 9) == 0)
				write_joint_count(LANE_W'($urandom_range(0, 7)));
			steady_source = ($urandom_range(0, 4) == 0);
			steady_sink   = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			len = (r < 10) ? 1 : (r < 85) ? $urandom_range(2, 8) : $urandom_range(9, 30);
			run_trajectory(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1);
			sent += len;
		end
		steady_source = 1'b0;
		steady_sink   = 1'b0;
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_write             = 1'b0;
		cfg_data              = '0;
		samples_if.valid      = 1'b0;
		samples_if.time_ns    = '0;
		samples_if.position_0 = '0;
		samples_if.position_1 = '0;
		samples_if.position_2 = '0;
		samples_if.position_3 = '0;
		samples_if.position_4 = '0;
		samples_if.position_5 = '0;
		samples_if.last_point = 1'b0;
		vel_if.ready          = 1'b0;
		older_pos             = '0;
		newer_pos             = '0;
		older_stamp           = '0;
		newer_stamp           = '0;
		points_held           = 0;
		joint_count           = LANE_W'(JOINTS);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_joint_counts();
		test_backpressure();
		test_drain_pause();
		test_random();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (velocity_words_due.size() != 0) begin
			error_count += velocity_words_due.size();
			$display("%0d expected words never arrived", velocity_words_due.size());
		end
		$display("sent %0d points over %0d joint-count settings, checked %0d velocity words",
			points_sent, config_writes, words_checked);
		$display("%0d words had a bad interval; %0d mismatches in %0d cycles",
			bad_words, error_count, cycle_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/fdv_pkg.sv
design/fdv_if.sv
design/fdv_div.sv
design/fdv_dp.sv
design/fdv_ctrl.sv
design/finite_difference_velocity.sv
dv/tb.sv
